[hdl/tat_pkg.sv]
// Shared types and codes for the task alarm table.
// Holds command/status codes, beat structs and the per-slot memory record.
// No dependencies.
`default_nettype none

package tat_pkg;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;
	localparam logic [1:0] CMD_SYNC   = 2'd3;

	localparam logic [2:0] RSP_ADDED     = 3'd0;
	localparam logic [2:0] RSP_FULL      = 3'd1;
	localparam logic [2:0] RSP_REMOVED   = 3'd2;
	localparam logic [2:0] RSP_NOT_FOUND = 3'd3;
	localparam logic [2:0] RSP_FIRED     = 3'd4;
	localparam logic [2:0] RSP_NONE_DUE  = 3'd5;
	localparam logic [2:0] RSP_SYNCED    = 3'd6;

	localparam int MAX_RESULTS = 16;
	localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] now_time;
		logic [31:0] start_time;
		logic [31:0] period;
		logic        repeat_req;
		logic [15:0] task_id;
		logic [31:0] old_time;
	} cmd_beat_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] result_id;
		logic        rescheduled;
		logic        last;
	} rsp_beat_t;

	typedef struct packed {
		logic [31:0] due_time;
		logic [31:0] interval;
		logic        repeat_flag;
		logic [15:0] slot_id;
		logic        time_adjusted;
	} slot_rec_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

endpackage

`default_nettype wire

[hdl/task_alarm_table_top.sv]
// Task alarm table: slot scan engine over one record memory plus armed bits.
// Depends on tat_pkg and tat_ram.
//
//  channel | direction | handshake            | payload
//  cmd     | in        | cmd_valid/cmd_ready  | tat_pkg::cmd_beat_t
//  rsp     | out       | rsp_valid/rsp_ready  | tat_pkg::rsp_beat_t
//
// Each command sweeps the slots one per cycle through the record memory read
// port while nothing stalls; add and remove stop after their hit, a tick stops
// after MAX_RESULTS fires.
// Reset clears the armed bits, ids and sync flag; no memory clearing pass.
// A tick stalls its sweep while a fired beat finds the output register full.
// A new command is taken while the last result beat still waits in rsp.
`default_nettype none

module task_alarm_table_top #(
	parameter int SLOTS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_ready,
	input  wire tat_pkg::cmd_beat_t cmd,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output tat_pkg::rsp_beat_t      rsp
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int REC_W = $bits(tat_pkg::slot_rec_t);

	tat_pkg::state_t     st_q;
	tat_pkg::cmd_beat_t  cmd_q;
	logic [SLOTS-1:0]    armed_q;
	logic                clock_synced_q;
	logic [15:0]         next_id_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                done_q;
	logic [tat_pkg::FIRE_W-1:0] n_q;
	logic                ev_valid_s1;
	logic [IDX_W-1:0]    ev_idx_s1;
	logic                pend_valid_q;
	tat_pkg::rsp_beat_t  pend_q;
	tat_pkg::rsp_beat_t  out_q;
	logic                out_valid_q;

	logic [REC_W-1:0]    ram_rdata;
	tat_pkg::slot_rec_t  rec;
	tat_pkg::slot_rec_t  wrec;
	tat_pkg::rsp_beat_t  hit_rsp;
	tat_pkg::rsp_beat_t  push_rsp;
	logic                armed_ev;
	logic                ev_act;
	logic                hit;
	logic                resc;
	logic                out_free;
	logic                stall;
	logic                do_eval;
	logic                issue;
	logic                finish;
	logic                push;
	logic                ram_we;
	logic                scan_end;
	logic [2:0]          miss_status;

	assign rec       = tat_pkg::slot_rec_t'(ram_rdata);
	assign armed_ev  = armed_q[ev_idx_s1];
	assign ev_act    = ev_valid_s1 && !done_q;
	assign out_free  = !out_valid_q || rsp_ready;
	assign scan_end  = done_q || (cnt_q == CNT_W'(SLOTS));

	always_comb begin
		hit         = 1'b0;
		resc        = 1'b0;
		wrec        = rec;
		hit_rsp     = '0;
		miss_status = tat_pkg::RSP_SYNCED;
		unique case (cmd_q.command)
			tat_pkg::CMD_ADD: begin
				hit                = !armed_ev;
				wrec.due_time      = (cmd_q.start_time != 32'd0) ? cmd_q.start_time
					: cmd_q.now_time + cmd_q.period;
				wrec.interval      = cmd_q.period;
				wrec.repeat_flag   = cmd_q.repeat_req;
				wrec.slot_id       = next_id_q;
				wrec.time_adjusted = clock_synced_q;
				hit_rsp.status     = tat_pkg::RSP_ADDED;
				hit_rsp.result_id  = next_id_q;
				miss_status        = tat_pkg::RSP_FULL;
			end
			tat_pkg::CMD_REMOVE: begin
				hit               = armed_ev && (rec.slot_id == cmd_q.task_id);
				hit_rsp.status    = tat_pkg::RSP_REMOVED;
				hit_rsp.result_id = cmd_q.task_id;
				miss_status       = tat_pkg::RSP_NOT_FOUND;
			end
			tat_pkg::CMD_TICK: begin
				hit                 = armed_ev && (rec.due_time <= cmd_q.now_time);
				resc                = rec.repeat_flag && (rec.interval != 32'd0);
				wrec.due_time       = resc ? cmd_q.now_time + rec.interval : rec.due_time;
				wrec.time_adjusted  = rec.time_adjusted | clock_synced_q;
				hit_rsp.status      = tat_pkg::RSP_FIRED;
				hit_rsp.result_id   = rec.slot_id;
				hit_rsp.rescheduled = resc;
				miss_status         = tat_pkg::RSP_NONE_DUE;
			end
			tat_pkg::CMD_SYNC: begin
				hit                = armed_ev && !rec.time_adjusted;
				wrec.due_time      = cmd_q.now_time + (rec.due_time - cmd_q.old_time);
				wrec.time_adjusted = 1'b1;
				miss_status        = tat_pkg::RSP_SYNCED;
			end
			default: begin
				hit = 1'b0;
			end
		endcase
	end

	assign stall   = ev_act && hit && (cmd_q.command == tat_pkg::CMD_TICK)
		&& pend_valid_q && !out_free;
	assign do_eval = ev_act && hit && !stall;
	assign ram_we  = do_eval && (cmd_q.command != tat_pkg::CMD_REMOVE);
	assign issue   = (st_q == tat_pkg::S_SCAN) && !scan_end && !stall;
	assign finish  = (st_q == tat_pkg::S_SCAN) && !ev_act && scan_end && out_free;
	assign push    = finish
		|| (do_eval && (cmd_q.command == tat_pkg::CMD_TICK) && pend_valid_q);

	always_comb begin
		push_rsp      = pend_q;
		push_rsp.last = 1'b0;
		if (finish) begin
			push_rsp.last = 1'b1;
			if (!pend_valid_q) begin
				push_rsp.status      = miss_status;
				push_rsp.result_id   = 16'd0;
				push_rsp.rescheduled = 1'b0;
			end
		end
	end

	tat_ram #(
		.WIDTH(REC_W),
		.DEPTH(SLOTS)
	) u_rec_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ev_idx_s1),
		.wdata(wrec),
		.re   (issue),
		.raddr(cnt_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= tat_pkg::S_IDLE;
			armed_q        <= '0;
			clock_synced_q <= 1'b0;
			next_id_q      <= 16'd0;
			cnt_q          <= '0;
			done_q         <= 1'b0;
			n_q            <= '0;
			ev_valid_s1    <= 1'b0;
			pend_valid_q   <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				tat_pkg::S_IDLE: begin
					if (cmd_valid) begin
						st_q         <= tat_pkg::S_SCAN;
						cnt_q        <= '0;
						done_q       <= 1'b0;
						n_q          <= '0;
						ev_valid_s1  <= 1'b0;
						pend_valid_q <= 1'b0;
						if (cmd.command == tat_pkg::CMD_SYNC) begin
							clock_synced_q <= 1'b1;
						end
					end
				end
				tat_pkg::S_SCAN: begin
					if (!stall) begin
						ev_valid_s1 <= issue;
					end
					if (issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (do_eval) begin
						unique case (cmd_q.command)
							tat_pkg::CMD_ADD: begin
								armed_q[ev_idx_s1] <= 1'b1;
								next_id_q          <= next_id_q + 16'd1;
								done_q             <= 1'b1;
							end
							tat_pkg::CMD_REMOVE: begin
								armed_q[ev_idx_s1] <= 1'b0;
								done_q             <= 1'b1;
							end
							tat_pkg::CMD_TICK: begin
								if (!resc) begin
									armed_q[ev_idx_s1] <= 1'b0;
								end
								n_q <= n_q + tat_pkg::FIRE_W'(1);
								if (n_q == tat_pkg::FIRE_W'(tat_pkg::MAX_RESULTS - 1)) begin
									done_q <= 1'b1;
								end
							end
							tat_pkg::CMD_SYNC: begin
								done_q <= done_q;
							end
							default: begin
								done_q <= done_q;
							end
						endcase
						if (cmd_q.command != tat_pkg::CMD_SYNC) begin
							pend_valid_q <= 1'b1;
						end
					end
					if (finish) begin
						st_q         <= tat_pkg::S_IDLE;
						pend_valid_q <= 1'b0;
					end
				end
				default: begin
					st_q <= tat_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_q <= cmd;
		end
		if (issue) begin
			ev_idx_s1 <= cnt_q[IDX_W-1:0];
		end
		if (do_eval) begin
			pend_q <= hit_rsp;
		end
		if (push) begin
			out_q <= push_rsp;
		end
	end

	assign cmd_ready = (st_q == tat_pkg::S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == tat_pkg::S_IDLE) |-> !pend_valid_q)
		else $error("pending result left when idle");

	a_fire_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= tat_pkg::FIRE_W'(tat_pkg::MAX_RESULTS))
		else $error("fired count beyond limit");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> (out_valid_q && !rsp_ready))
		else $error("sweep stalled with output free");

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (st_q == tat_pkg::S_IDLE) && out_valid_q && out_q.last)
		else $error("sweep end without final beat");

	a_no_write_stall: assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> !ram_we && !issue)
		else $error("memory access during stall");

endmodule

`default_nettype wire

[hdl/tat_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Parameters set word width and depth. No dependencies.
`default_nettype none

module tat_ram #(
	parameter int WIDTH = 82,
	parameter int DEPTH = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                     wdata,
	input  wire logic                                 re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[test/task_alarm_table_chk.sv]
// Checker for the task alarm table: watches the cmd and rsp channels, keeps a
// shadow copy of the alarm slots and compares every response beat in order.
// Depends on tat_pkg.
`timescale 1ns / 1ps

module task_alarm_table_chk #(
	parameter int SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_ready,
	input  tat_pkg::cmd_beat_t cmd,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  tat_pkg::rsp_beat_t rsp,
	output int                 errors,
	output int                 outstanding
);

	logic        armed[SLOTS];
	logic [31:0] due_at[SLOTS];
	logic [31:0] interval[SLOTS];
	logic        repeats[SLOTS];
	logic [15:0] tag[SLOTS];
	logic        adjusted[SLOTS];
	logic        synced;
	logic [15:0] next_tag;

	tat_pkg::rsp_beat_t alarm_rsp_q[$];
	int                 err_count = 0;

	assign errors = err_count;

	task automatic report(input string what);
		$display("%0t mismatch: %s", $time, what);
		err_count++;
	endtask

	task automatic alarm_step(input tat_pkg::cmd_beat_t c);
		int                 i;
		int                 fired;
		logic               hit;
		logic               have_held;
		tat_pkg::rsp_beat_t r;
		tat_pkg::rsp_beat_t held;
		r = '0;
		r.last = 1'b1;
		hit = 1'b0;
		have_held = 1'b0;
		held = '0;
		fired = 0;
		case (c.command)
			tat_pkg::CMD_ADD: begin
				r.status = tat_pkg::RSP_FULL;
				for (i = 0; i < SLOTS && !hit; i++) begin
					if (!armed[i]) begin
						hit = 1'b1;
						armed[i] = 1'b1;
						due_at[i] = (c.start_time != 32'd0) ? c.start_time
							: c.now_time + c.period;
						interval[i] = c.period;
						repeats[i] = c.repeat_req;
						tag[i] = next_tag;
						adjusted[i] = synced;
						r.status = tat_pkg::RSP_ADDED;
						r.result_id = next_tag;
						next_tag = next_tag + 16'd1;
					end
				end
				alarm_rsp_q.push_back(r);
			end
			tat_pkg::CMD_REMOVE: begin
				r.status = tat_pkg::RSP_NOT_FOUND;
				for (i = 0; i < SLOTS && !hit; i++) begin
					if (armed[i] && tag[i] == c.task_id) begin
						hit = 1'b1;
						armed[i] = 1'b0;
						r.status = tat_pkg::RSP_REMOVED;
						r.result_id = c.task_id;
					end
				end
				alarm_rsp_q.push_back(r);
			end
			tat_pkg::CMD_TICK: begin
				for (i = 0; i < SLOTS && fired < tat_pkg::MAX_RESULTS; i++) begin
					if (armed[i] && due_at[i] <= c.now_time) begin
						if (have_held)
							alarm_rsp_q.push_back(held);
						held = '0;
						held.status = tat_pkg::RSP_FIRED;
						held.result_id = tag[i];
						if (synced)
							adjusted[i] = 1'b1;
						if (repeats[i] && interval[i] != 32'd0) begin
							due_at[i] = c.now_time + interval[i];
							held.rescheduled = 1'b1;
						end else begin
							armed[i] = 1'b0;
						end
						have_held = 1'b1;
						fired++;
					end
				end
				if (have_held) begin
					held.last = 1'b1;
					alarm_rsp_q.push_back(held);
				end else begin
					r.status = tat_pkg::RSP_NONE_DUE;
					alarm_rsp_q.push_back(r);
				end
			end
			tat_pkg::CMD_SYNC: begin
				synced = 1'b1;
				for (i = 0; i < SLOTS; i++) begin
					if (armed[i] && !adjusted[i]) begin
						due_at[i] = c.now_time + (due_at[i] - c.old_time);
						adjusted[i] = 1'b1;
					end
				end
				r.status = tat_pkg::RSP_SYNCED;
				alarm_rsp_q.push_back(r);
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		tat_pkg::rsp_beat_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				armed[i] = 1'b0;
			synced = 1'b0;
			next_tag = 16'd0;
			alarm_rsp_q.delete();
			outstanding <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (alarm_rsp_q.size() == 0) begin
					report($sformatf("unrequested beat status %0d id %0h",
						rsp.status, rsp.result_id));
				end else begin
					want = alarm_rsp_q.pop_front();
					if (rsp.status !== want.status)
						report($sformatf("status got %0d want %0d",
							rsp.status, want.status));
					if (rsp.result_id !== want.result_id)
						report($sformatf("result_id got %0h want %0h",
							rsp.result_id, want.result_id));
					if (rsp.rescheduled !== want.rescheduled)
						report($sformatf("rescheduled got %b want %b",
							rsp.rescheduled, want.rescheduled));
					if (rsp.last !== want.last)
						report($sformatf("last got %b want %b",
							rsp.last, want.last));
				end
			end
			if (cmd_valid && cmd_ready)
				alarm_step(cmd);
			outstanding <= alarm_rsp_q.size();
		end
	end

	final begin
		if (alarm_rsp_q.size() != 0)
			$display("%0t mismatch: %0d beats never arrived", $time, alarm_rsp_q.size());
	end

endmodule

[test/task_alarm_table_top_tb.sv]
// Testbench top for the task alarm table: clock, reset, command stimulus and
// response back-pressure; checking is done by task_alarm_table_chk.
// Depends on tat_pkg, task_alarm_table_top and task_alarm_table_chk.
`timescale 1ns / 1ps

module task_alarm_table_top_tb;

	localparam int SLOTS        = 16;
	localparam int RANDOM_BEATS = 460;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 60;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cmd_valid = 1'b0;
	logic               cmd_ready;
	tat_pkg::cmd_beat_t cmd       = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	tat_pkg::rsp_beat_t rsp;
	logic               calm      = 1'b0;
	int                 errors;
	int                 outstanding;
	int unsigned        cycles    = 0;
	int                 hold      = 0;
	logic [15:0]        id_pool[$];
	logic [31:0]        clock_now;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task_alarm_table_top #(
		.SLOTS(SLOTS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	task_alarm_table_chk #(
		.SLOTS(SLOTS)
	) u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.errors     (errors),
		.outstanding(outstanding)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 2);
		if (r < 93)
			return $urandom_range(3, 6);
		return $urandom_range(10, 24);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// stall the response side
	always @(posedge clk) begin
		if (hold != 0) begin
			hold <= hold - 1;
			rsp_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			hold <= pick_gap();
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// collect issued ids for later removes
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready && rsp.status == tat_pkg::RSP_ADDED) begin
			id_pool.push_back(rsp.result_id);
			if (id_pool.size() > 32)
				void'(id_pool.pop_front());
		end
	end

	function automatic tat_pkg::cmd_beat_t noise_beat();
		tat_pkg::cmd_beat_t b;
		b.command    = 2'($urandom);
		b.now_time   = $urandom;
		b.start_time = $urandom;
		b.period     = $urandom;
		b.repeat_req = 1'($urandom);
		b.task_id    = 16'($urandom);
		b.old_time   = $urandom;
		return b;
	endfunction

	function automatic tat_pkg::cmd_beat_t add_beat(input logic [31:0] now,
		input logic [31:0] start, input logic [31:0] period, input logic rep);
		tat_pkg::cmd_beat_t b;
		b = noise_beat();
		b.command    = tat_pkg::CMD_ADD;
		b.now_time   = now;
		b.start_time = start;
		b.period     = period;
		b.repeat_req = rep;
		return b;
	endfunction

	function automatic tat_pkg::cmd_beat_t remove_beat(input logic [15:0] id);
		tat_pkg::cmd_beat_t b;
		b = noise_beat();
		b.command = tat_pkg::CMD_REMOVE;
		b.task_id = id;
		return b;
	endfunction

	function automatic tat_pkg::cmd_beat_t tick_beat(input logic [31:0] now);
		tat_pkg::cmd_beat_t b;
		b = noise_beat();
		b.command  = tat_pkg::CMD_TICK;
		b.now_time = now;
		return b;
	endfunction

	function automatic tat_pkg::cmd_beat_t sync_beat(input logic [31:0] now,
		input logic [31:0] old);
		tat_pkg::cmd_beat_t b;
		b = noise_beat();
		b.command  = tat_pkg::CMD_SYNC;
		b.now_time = now;
		b.old_time = old;
		return b;
	endfunction

	task automatic send_beat(input tat_pkg::cmd_beat_t b);
		int gap;
		gap = calm ? 0 : pick_gap();
		cmd <= b;
		cmd_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cmd_ready);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	initial begin
		int                 r;
		int                 k;
		logic [31:0]        start;
		logic [31:0]        period;
		tat_pkg::cmd_beat_t b;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(tick_beat(32'd0));
		send_beat(remove_beat(16'd0));
		send_beat(add_beat(32'd100, 32'd0, 32'd50, 1'b1));
		send_beat(add_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
		send_beat(add_beat(32'd100, 32'd200, 32'd0, 1'b1));
		send_beat(add_beat(32'd100, 32'd120, 32'd10, 1'b0));
		for (k = 0; k < SLOTS - 4; k++)
			send_beat(add_beat(32'd110, 32'd300 + k, k, k[0]));
		send_beat(add_beat(32'd0, 32'd0, 32'd0, 1'b0));
		send_beat(tick_beat(32'd160));
		send_beat(sync_beat(32'd1000, 32'd160));
		send_beat(sync_beat(32'd5, 32'd0));
		send_beat(remove_beat(16'd1));
		send_beat(tick_beat(32'hFFFF_FFFF));
		send_beat(tick_beat(32'd0));
		settle();

		clock_now = $urandom_range(0, 5000);
		for (k = 0; k < RANDOM_BEATS; k++) begin
			if ($urandom_range(0, 59) == 0)
				calm <= !calm;
			if (k == RANDOM_BEATS / 2)
				settle();
			r = $urandom_range(0, 99);
			if (r < 35) begin
				r = $urandom_range(0, 9);
				start = (r < 4) ? 32'd0 : (r < 8) ? clock_now + $urandom_range(0, 60)
					: $urandom;
				r = $urandom_range(0, 9);
				period = (r < 7) ? $urandom_range(1, 50) : (r < 9) ? 32'd0 : $urandom;
				b = add_beat($urandom_range(0, 9) == 0 ? $urandom : clock_now,
					start, period, 1'($urandom));
			end else if (r < 55) begin
				if (id_pool.size() != 0 && $urandom_range(0, 99) < 85) begin
					r = $urandom_range(0, id_pool.size() - 1);
					b = remove_beat(id_pool[r]);
					id_pool.delete(r);
				end else begin
					b = remove_beat(16'($urandom));
				end
			end else if (r < 90) begin
				clock_now = clock_now + $urandom_range(0, 40);
				r = $urandom_range(0, 19);
				b = tick_beat(r == 0 ? 32'hFFFF_FFFF : r == 1 ? $urandom : clock_now);
			end else begin
				r = $urandom_range(0, 4);
				b = sync_beat(r == 0 ? $urandom : clock_now + $urandom_range(0, 500),
					r == 1 ? $urandom : clock_now);
				clock_now = b.now_time;
			end
			send_beat(b);
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
